// ===== sv/c16df_pkg.sv =====
package c16df_pkg;

  // register indexes of the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgSofFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSofSecond = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgCrcSeed   = 2'd2;
  localparam int unsigned CfgDataW = 16;

  // reset values of the registers
  localparam logic [7:0]  SofFirstRst  = 8'hAA;
  localparam logic [7:0]  SofSecondRst = 8'h55;
  localparam logic [15:0] CrcSeedRst   = 16'hFFFF;

  // crc-16, msb first
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcTop  = 16'h8000;

  // header is version, type, flags, two sequence bytes, two length bytes
  localparam logic [15:0] HeaderLast = 16'd6;

  // result kinds
  localparam logic [1:0] KindPayload = 2'd0;
  localparam logic [1:0] KindCrcGood = 2'd1;
  localparam logic [1:0] KindCrcBad  = 2'd2;

  // configuration write from the port
  typedef struct packed {
    logic                we;
    logic [CfgIdxW-1:0]  idx;
    logic [CfgDataW-1:0] data;
  } cfg_wr_t;

  // one result item
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [7:0]  version;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [15:0] sequence_res;
    logic [15:0] payload_length;
    logic [15:0] received_crc;
    logic [31:0] frame_bytes;
  } result_t;

  // one byte through the crc register
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcTop) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== sv/crc16_packet_deframer_top.sv =====
// Byte-stream deframer: hunts for the two start-of-frame markers, captures the
// seven-byte header, passes each payload byte out as an item and ends each frame
// with one item carrying the header, the trailer CRC, a good/bad CRC verdict
// (CRC-16 0x1021, msb first, seeded from crc_seed) and the count of bytes
// consumed since the last frame end. One byte is taken every cycle unless
// in_stall_o is set; a byte is held in an input register, parsed combinationally
// (bytewise CRC plus phase update) and its result, if any, goes to the output
// register. Output stall backs up into in_stall_o only when the output register
// is full and not being taken. Configuration writes apply immediately.
module crc16_packet_deframer_top
  import c16df_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [1:0]          kind_o,
  output logic [7:0]          payload_byte_o,
  output logic [7:0]          version_o,
  output logic [7:0]          frame_type_o,
  output logic [7:0]          frame_flags_o,
  output logic [15:0]         sequence_res_o,
  output logic [15:0]         payload_length_o,
  output logic [15:0]         received_crc_o,
  output logic [31:0]         frame_bytes_o
);

  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       out_vld_q;
  result_t    out_q;

  logic       step;
  logic       accept;
  logic       res_valid;
  result_t    res;
  cfg_wr_t    cfg_wr;

  // flow control
  assign step       = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !step;
  assign accept     = in_valid_i && !in_stall_o;

  assign cfg_wr = '{we: cfg_we_i, idx: cfg_idx_i, data: cfg_wdata_i};

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (accept) begin
      in_vld_q <= 1'b1;
    end else if (step) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) in_byte_q <= rx_byte_i;
  end

  c16df_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_wr),
    .step_i      (step),
    .byte_i      (in_byte_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= res_valid;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) out_q <= res;
  end

  assign out_valid_o      = out_vld_q;
  assign kind_o           = out_q.kind;
  assign payload_byte_o   = out_q.payload_byte;
  assign version_o        = out_q.version;
  assign frame_type_o     = out_q.frame_type;
  assign frame_flags_o    = out_q.frame_flags;
  assign sequence_res_o   = out_q.sequence_res;
  assign payload_length_o = out_q.payload_length;
  assign received_crc_o   = out_q.received_crc;
  assign frame_bytes_o    = out_q.frame_bytes;

endmodule

// ===== sv/c16df_core.sv =====
module c16df_core
  import c16df_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_wr_t    cfg_i,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  output logic       res_valid_o,
  output result_t    res_o
);

  typedef enum logic [2:0] {
    PhHunt1,
    PhHunt2,
    PhHeader,
    PhPayload,
    PhCrcHi,
    PhCrcLo
  } phase_e;

  logic [7:0]  sof_first_q, sof_second_q;
  logic [15:0] crc_seed_q;

  phase_e      phase_q, phase_d;
  logic [15:0] pos_q, pos_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  version_q, version_d;
  logic [7:0]  type_q, type_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] seq_q, seq_d;
  logic [15:0] len_q, len_d;
  logic [7:0]  crc_hi_q, crc_hi_d;
  logic [31:0] seen_q, seen_d;

  logic [15:0] crc_next;
  logic [15:0] pos_inc;
  logic [31:0] seen_inc;
  logic [15:0] rx_crc;

  assign crc_next = crc_update(crc_q, byte_i);
  assign pos_inc  = pos_q + 16'd1;
  assign seen_inc = (seen_q == 32'hFFFF_FFFF) ? seen_q : seen_q + 32'd1;
  assign rx_crc   = {crc_hi_q, byte_i};

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sof_first_q  <= SofFirstRst;
      sof_second_q <= SofSecondRst;
      crc_seed_q   <= CrcSeedRst;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        CfgSofFirst:  sof_first_q  <= cfg_i.data[7:0];
        CfgSofSecond: sof_second_q <= cfg_i.data[7:0];
        CfgCrcSeed:   crc_seed_q   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // parse one byte
  always_comb begin
    phase_d     = phase_q;
    pos_d       = pos_q;
    crc_d       = crc_q;
    version_d   = version_q;
    type_d      = type_q;
    flags_d     = flags_q;
    seq_d       = seq_q;
    len_d       = len_q;
    crc_hi_d    = crc_hi_q;
    seen_d      = seen_inc;
    res_valid_o = 1'b0;
    res_o       = '{kind: KindPayload, payload_byte: 8'h00, version: version_q,
                    frame_type: type_q, frame_flags: flags_q, sequence_res: seq_q,
                    payload_length: len_q, received_crc: 16'h0000,
                    frame_bytes: 32'h0000_0000};
    case (phase_q)
      PhHunt1: begin
        if (byte_i == sof_first_q) phase_d = PhHunt2;
      end
      PhHunt2: begin
        // second marker wins when both markers are equal
        if (byte_i == sof_second_q) begin
          phase_d = PhHeader;
          pos_d   = 16'd0;
          crc_d   = crc_seed_q;
        end else if (byte_i != sof_first_q) begin
          phase_d = PhHunt1;
        end
      end
      PhHeader: begin
        crc_d = crc_next;
        case (pos_q[2:0])
          3'd0:    version_d = byte_i;
          3'd1:    type_d    = byte_i;
          3'd2:    flags_d   = byte_i;
          3'd3:    seq_d     = {byte_i, 8'h00};
          3'd4:    seq_d     = {seq_q[15:8], byte_i};
          3'd5:    len_d     = {byte_i, 8'h00};
          default: len_d     = {len_q[15:8], byte_i};
        endcase
        pos_d = pos_inc;
        if (pos_q >= HeaderLast) begin
          pos_d   = 16'd0;
          phase_d = (len_d == 16'd0) ? PhCrcHi : PhPayload;
        end
      end
      PhPayload: begin
        crc_d = crc_next;
        pos_d = pos_inc;
        if (pos_inc == len_q) phase_d = PhCrcHi;
        res_valid_o        = 1'b1;
        res_o.payload_byte = byte_i;
      end
      PhCrcHi: begin
        crc_hi_d = byte_i;
        phase_d  = PhCrcLo;
      end
      PhCrcLo: begin
        res_valid_o        = 1'b1;
        res_o.kind         = (rx_crc == crc_q) ? KindCrcGood : KindCrcBad;
        res_o.received_crc = rx_crc;
        res_o.frame_bytes  = seen_inc;
        seen_d             = 32'h0000_0000;
        pos_d              = 16'd0;
        phase_d            = PhHunt1;
      end
      default: phase_d = PhHunt1;
    endcase
  end

  // parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHunt1;
      pos_q     <= 16'd0;
      crc_q     <= 16'd0;
      version_q <= 8'd0;
      type_q    <= 8'd0;
      flags_q   <= 8'd0;
      seq_q     <= 16'd0;
      len_q     <= 16'd0;
      crc_hi_q  <= 8'd0;
      seen_q    <= 32'd0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      pos_q     <= pos_d;
      crc_q     <= crc_d;
      version_q <= version_d;
      type_q    <= type_d;
      flags_q   <= flags_d;
      seq_q     <= seq_d;
      len_q     <= len_d;
      crc_hi_q  <= crc_hi_d;
      seen_q    <= seen_d;
    end
  end

endmodule
